[rtl/core/bsed_pkg.sv]
// Shared types, character codes and lookup functions for the backslash escape decoder.
package bsed_pkg;

    localparam int unsigned ValueWidth = 24;
    localparam int unsigned MaxResults = 3;
    localparam int unsigned EscTableSize = 13;

    // Escape decoder phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_CTRL,
        PH_OCT,
        PH_HEX
    } t_phase;

    // Character codes that the decoder tests against.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_C         = 8'h63;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_7         = 8'h37;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_LO_A      = 8'h61;
    localparam logic [7:0] CH_LO_F      = 8'h66;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_UP_F      = 8'h46;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_LO_U      = 8'h75;
    localparam logic [7:0] CH_UP_U      = 8'h55;
    localparam logic [7:0] CTRL_MASK    = 8'd31;

    // Digit limits of the octal and hex escapes.
    localparam logic [2:0] OCT_DIGITS   = 3'd3;
    localparam logic [2:0] HEX_X_DIGITS = 3'd2;
    localparam logic [2:0] HEX_U_DIGITS = 3'd4;
    localparam logic [2:0] HEX_UU_DIGITS = 3'd6;

    // Register map.
    localparam int unsigned AddrWidth = 3;
    localparam logic REG_ECHO_MODE = 1'b0;

    // Single-letter escapes and their values.
    localparam logic [EscTableSize-1:0][7:0] ESC_LETTERS = {
        8'h3F, 8'h22, 8'h27, 8'h76, 8'h74, 8'h72, 8'h6E, 8'h66, 8'h45, 8'h65, 8'h62, 8'h61,
        8'h5C
    };
    localparam logic [EscTableSize-1:0][7:0] ESC_VALUES = {
        8'd63, 8'd34, 8'd39, 8'd11, 8'd9, 8'd13, 8'd10, 8'd12, 8'd27, 8'd27, 8'd8, 8'd7,
        8'd92
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [ValueWidth-1:0] char_value;
        logic                  run_last;
    } t_out_item;

    // Escape state carried from one byte to the next.
    typedef struct packed {
        t_phase                phase;
        logic [2:0]            digits_seen;
        logic [2:0]            digits_allowed;
        logic [ValueWidth-1:0] accumulator;
        logic [7:0]            escape_letter;
    } t_dec_state;

    localparam t_dec_state IDLE_STATE = '{
        phase: PH_IDLE,
        digits_seen: 3'd0,
        digits_allowed: 3'd0,
        accumulator: '0,
        escape_letter: 8'd0
    };

    // The results that one byte produces, in order.
    typedef struct packed {
        logic [1:0]                             cnt;
        logic [MaxResults-1:0][ValueWidth-1:0] vals;
    } t_res_buf;

    // Returns {hit, value} for a single-letter escape.
    function automatic logic [8:0] esc_lookup(input logic [7:0] b);
        logic [8:0] res;
        res = 9'd0;
        for (int i = 0; i < EscTableSize; i++) begin
            if (ESC_LETTERS[i] == b) begin
                res = {1'b1, ESC_VALUES[i]};
            end
        end
        return res;
    endfunction

    // Returns {valid, digit} for a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] res;
        if (b >= CH_0 && b <= CH_9) begin
            res = {1'b1, 4'(b - CH_0)};
        end else if (b >= CH_LO_A && b <= CH_LO_F) begin
            res = {1'b1, 4'(b - CH_LO_A + 8'd10)};
        end else if (b >= CH_UP_A && b <= CH_UP_F) begin
            res = {1'b1, 4'(b - CH_UP_A + 8'd10)};
        end else begin
            res = 5'd0;
        end
        return res;
    endfunction

endpackage

[rtl/core/bsed_cfg.sv]
// Configuration register file of the backslash escape decoder with its APB-style port.
module bsed_cfg
    import bsed_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output logic                 o_echo_mode
);

    logic r_echo_mode;
    logic n_echo_mode;
    logic reg_index;

    // Registers sit on 32-bit words; the low two address bits are ignored.
    assign reg_index = paddr[AddrWidth-1];

    always_comb begin
        n_echo_mode = r_echo_mode;
        if (psel && penable && pwrite && reg_index == REG_ECHO_MODE) begin
            n_echo_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_mode <= 1'b1;
        end else begin
            r_echo_mode <= n_echo_mode;
        end
    end

    assign prdata      = (reg_index == REG_ECHO_MODE) ? {31'd0, r_echo_mode} : 32'd0;
    assign pready      = 1'b1;
    assign o_echo_mode = r_echo_mode;

endmodule

[rtl/core/bsed_step.sv]
// Combinational decode of one byte against the escape state.
module bsed_step
    import bsed_pkg::*;
(
    input  t_dec_state i_state,
    input  t_in_item   i_item,
    input  logic       i_echo_mode,
    output t_dec_state o_next_state,
    output t_res_buf   o_results
);

    function automatic t_res_buf emit(input t_res_buf r, input logic [ValueWidth-1:0] v);
        t_res_buf e;
        e = r;
        if (e.cnt != 2'(MaxResults)) begin
            e.vals[e.cnt] = v;
            e.cnt = e.cnt + 2'd1;
        end
        return e;
    endfunction

    always_comb begin
        t_dec_state s;
        t_res_buf   r;
        logic [7:0] b;
        logic [4:0] hex;
        logic [8:0] esc;

        s   = i_state;
        r   = '0;
        b   = i_item.in_byte;
        hex = hex_digit(b);
        esc = esc_lookup(b);

        case (s.phase)
            PH_ESC: begin
                s = IDLE_STATE;
                if (b == CH_C) begin
                    s.phase = PH_CTRL;
                end else if (i_echo_mode && b == CH_0) begin
                    s.phase          = PH_OCT;
                    s.digits_allowed = OCT_DIGITS;
                end else if (!i_echo_mode && b inside {[CH_0:CH_7]}) begin
                    s.phase          = PH_OCT;
                    s.digits_allowed = OCT_DIGITS;
                    s.digits_seen    = 3'd1;
                    s.accumulator    = ValueWidth'(b[2:0]);
                end else if (b inside {CH_X, CH_LO_U, CH_UP_U}) begin
                    s.phase          = PH_HEX;
                    s.escape_letter  = b;
                    s.digits_allowed = (b == CH_X) ? HEX_X_DIGITS :
                                       (b == CH_LO_U) ? HEX_U_DIGITS : HEX_UU_DIGITS;
                end else if (esc[8]) begin
                    r = emit(r, ValueWidth'(esc[7:0]));
                end else begin
                    // Unknown escape: the backslash goes out and the letter is
                    // handled again. It cannot be a backslash, which the table holds.
                    r = emit(r, ValueWidth'(CH_BACKSLASH));
                    r = emit(r, ValueWidth'(b));
                end
            end
            PH_CTRL: begin
                s = IDLE_STATE;
                r = emit(r, ValueWidth'(b & CTRL_MASK));
                if (b == CH_BACKSLASH) begin
                    s.phase = PH_ESC;
                end else begin
                    r = emit(r, ValueWidth'(b));
                end
            end
            PH_OCT: begin
                if (b inside {[CH_0:CH_7]}) begin
                    s.accumulator = {s.accumulator[ValueWidth-4:0], b[2:0]};
                    s.digits_seen = s.digits_seen + 3'd1;
                    if (s.digits_seen >= s.digits_allowed) begin
                        r = emit(r, s.accumulator);
                        s = IDLE_STATE;
                    end
                end else begin
                    r = emit(r, s.accumulator);
                    s = IDLE_STATE;
                    if (b == CH_BACKSLASH) begin
                        s.phase = PH_ESC;
                    end else begin
                        r = emit(r, ValueWidth'(b));
                    end
                end
            end
            PH_HEX: begin
                if (hex[4]) begin
                    s.accumulator = {s.accumulator[ValueWidth-5:0], hex[3:0]};
                    s.digits_seen = s.digits_seen + 3'd1;
                    if (s.digits_seen >= s.digits_allowed) begin
                        r = emit(r, s.accumulator);
                        s = IDLE_STATE;
                    end
                end else begin
                    if (s.digits_seen == 3'd0) begin
                        r = emit(r, ValueWidth'(CH_BACKSLASH));
                        r = emit(r, ValueWidth'(s.escape_letter));
                    end else begin
                        r = emit(r, s.accumulator);
                    end
                    s = IDLE_STATE;
                    if (b == CH_BACKSLASH) begin
                        s.phase = PH_ESC;
                    end else begin
                        r = emit(r, ValueWidth'(b));
                    end
                end
            end
            default: begin
                s = IDLE_STATE;
                if (b == CH_BACKSLASH) begin
                    s.phase = PH_ESC;
                end else begin
                    r = emit(r, ValueWidth'(b));
                end
            end
        endcase

        // At the end of the text a pending escape is closed out.
        if (i_item.end_of_text) begin
            case (s.phase)
                PH_ESC: begin
                    r = emit(r, ValueWidth'(CH_BACKSLASH));
                end
                PH_CTRL: begin
                    r = emit(r, '0);
                end
                PH_OCT: begin
                    r = emit(r, s.accumulator);
                end
                PH_HEX: begin
                    if (s.digits_seen == 3'd0) begin
                        r = emit(r, ValueWidth'(CH_BACKSLASH));
                        r = emit(r, ValueWidth'(s.escape_letter));
                    end else begin
                        r = emit(r, s.accumulator);
                    end
                end
                default: begin
                end
            endcase
            s = IDLE_STATE;
        end

        o_next_state = s;
        o_results    = r;
    end

endmodule

[rtl/core/bsed_out.sv]
// Result register that holds the results of one byte and hands them out one per transfer.
module bsed_out
    import bsed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_res_buf  i_results,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic       r_valid;
    logic [1:0] r_idx;
    t_res_buf   r_buf;
    logic       is_last;
    logic       xfer;

    assign is_last = (r_idx == r_buf.cnt - 2'd1);
    assign xfer    = r_valid && i_out_ready;
    // The buffer can take new results when empty or when its last one leaves now.
    assign o_free  = !r_valid || (xfer && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= (i_results.cnt != 2'd0);
            r_idx   <= 2'd0;
        end else if (xfer) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_results;
        end
    end

    assign o_out_valid           = r_valid;
    assign o_out_data.char_value = r_buf.vals[r_idx];
    assign o_out_data.run_last   = is_last;

endmodule

[rtl/core/backslash_escape_decoder_top.sv]
// Top level of the backslash escape decoder: input register, escape state and result buffer.
// A byte goes into the input register, then into the result buffer once that is free.
// Throughput: one byte per cycle while each byte gives at most one result and results are
// taken; a byte with two or three results holds the buffer until all leave, one per transfer.
// Reset (synchronous, active low): no escape pending, echo_mode set, both buffers empty.
module backslash_escape_decoder_top
    import bsed_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    // Result stream.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // The input register takes a byte on every transfer. The byte is decoded
    // from this register against the escape state, and the decode commits
    // (state update plus result buffer load) as soon as the result buffer
    // is free. Because the input register empties on that same commit, a new
    // byte can be taken in every cycle that the result side keeps moving.
    logic       r_in_valid;
    t_in_item   r_in;
    t_dec_state r_state;
    t_dec_state n_state;
    t_res_buf   step_results;
    logic       echo_mode;
    logic       res_free;
    logic       commit;

    bsed_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_echo_mode (echo_mode)
    );

    // All the escape handling for one byte is a single combinational step.
    bsed_step u_step (
        .i_state      (r_state),
        .i_item       (r_in),
        .i_echo_mode  (echo_mode),
        .o_next_state (n_state),
        .o_results    (step_results)
    );

    assign commit     = r_in_valid && res_free;
    assign o_in_ready = !r_in_valid || commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // The escape state only moves when a byte commits, so a byte that waits
    // for the result buffer sees the state left by the byte before it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE_STATE;
        end else if (commit) begin
            r_state <= n_state;
        end
    end

    // A byte that gives no result commits without loading anything visible.
    bsed_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (commit),
        .i_results   (step_results),
        .o_free      (res_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the backslash escape decoder: stimulus, prediction and checking.
module tb_top
    import bsed_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Register addresses: one 32-bit register per word, plus one address past the list.
    localparam logic [AddrWidth-1:0] ADDR_ECHO   = AddrWidth'(4 * int'(REG_ECHO_MODE));
    localparam logic [AddrWidth-1:0] ADDR_BEYOND = AddrWidth'(4 * (int'(REG_ECHO_MODE) + 1));

    // Single-letter escapes and the codes they stand for, kept pairwise by index.
    localparam int unsigned NumShortEsc = 13;
    localparam logic [NumShortEsc-1:0][7:0] SHORT_ESC_CHAR = {
        "\\", "a", "b", "e", "E", "f", "n", "r", "t", "v", "'", "\"", "?"
    };
    localparam logic [NumShortEsc-1:0][7:0] SHORT_ESC_CODE = {
        8'd92, 8'd7, 8'd8, 8'd27, 8'd27, 8'd12, 8'd10, 8'd13, 8'd9, 8'd11, 8'd39, 8'd34,
        8'd63
    };
    localparam logic [2:0][7:0] HEX_ESC_CHAR = {CH_X, CH_LO_U, CH_UP_U};

    // Clock, reset and every input of the block start at known values.
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    backslash_escape_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bytes waiting to be offered to the block, and characters it still owes us.
    t_in_item  pending_bytes [$];
    t_out_item expected_chars [$];
    int        error_count = 0;

    // Our own copy of the escape state and of the echo_mode register.
    t_phase                dec_phase   = PH_IDLE;
    logic [2:0]            dec_seen    = '0;
    logic [2:0]            dec_allowed = '0;
    logic [ValueWidth-1:0] dec_acc     = '0;
    logic [7:0]            dec_letter  = '0;
    logic                  echo_on     = 1'b1;

    // Characters produced by the byte being decoded, in order.
    logic [ValueWidth-1:0] step_vals [MaxResults];
    int                    step_cnt;

    // Pacing controls; the steady flags switch off idling on one side for a whole phase.
    logic        tx_steady = 1'b0;
    logic        rx_steady = 1'b0;
    int          burst_left = 8;
    int          gap_left   = 0;
    logic [15:0] stall_pattern = 16'h3C5B;
    logic [3:0]  stall_pos = '0;

    task automatic report_mismatch(input string what);
        error_count++;
        // Keep the log readable when the block is badly broken; the count still grows.
        if (error_count <= 40) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Decoder prediction.
    // ------------------------------------------------------------------

    function automatic void emit_char(input logic [ValueWidth-1:0] v);
        if (step_cnt < MaxResults) begin
            step_vals[step_cnt] = v;
            step_cnt++;
        end
    endfunction

    function automatic void clear_escape();
        dec_phase   = PH_IDLE;
        dec_seen    = '0;
        dec_allowed = '0;
        dec_acc     = '0;
        dec_letter  = '0;
    endfunction

    // A byte seen outside any escape: a backslash opens one, anything else is itself.
    function automatic void take_fresh(input logic [7:0] b);
        if (b == CH_BACKSLASH) begin
            dec_phase = PH_ESC;
        end else begin
            emit_char(ValueWidth'(b));
        end
    endfunction

    // Value of a hex digit character, or -1 when the byte is not one.
    function automatic int hex_digit_value(input logic [7:0] b);
        if (b >= CH_0 && b <= CH_9) begin
            return int'(b) - int'(CH_0);
        end
        if (b >= CH_LO_A && b <= CH_LO_F) begin
            return int'(b) - int'(CH_LO_A) + 10;
        end
        if (b >= CH_UP_A && b <= CH_UP_F) begin
            return int'(b) - int'(CH_UP_A) + 10;
        end
        return -1;
    endfunction

    // A hex escape that ends without filling its digits: value so far, or the escape
    // itself spelled out when no digit came at all.
    function automatic void close_hex();
        if (dec_seen == 0) begin
            emit_char(ValueWidth'(CH_BACKSLASH));
            emit_char(ValueWidth'(dec_letter));
        end else begin
            emit_char(dec_acc);
        end
        clear_escape();
    endfunction

    // The byte right after a backslash.
    function automatic void open_escape(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        clear_escape();
        if (b == CH_C) begin
            dec_phase = PH_CTRL;
        end else if (echo_on && b == CH_0) begin
            dec_phase   = PH_OCT;
            dec_allowed = OCT_DIGITS;
        end else if (!echo_on && b >= CH_0 && b <= CH_7) begin
            dec_phase   = PH_OCT;
            dec_allowed = OCT_DIGITS;
            dec_seen    = 3'd1;
            dec_acc     = ValueWidth'(b - CH_0);
        end else if (b == CH_X || b == CH_LO_U || b == CH_UP_U) begin
            dec_phase   = PH_HEX;
            dec_allowed = (b == CH_X) ? HEX_X_DIGITS :
                          (b == CH_LO_U) ? HEX_U_DIGITS : HEX_UU_DIGITS;
            dec_letter  = b;
        end else begin
            for (int i = 0; i < NumShortEsc; i++) begin
                if (!hit && SHORT_ESC_CHAR[i] == b) begin
                    emit_char(ValueWidth'(SHORT_ESC_CODE[i]));
                    hit = 1'b1;
                end
            end
            // Unknown letter: the backslash goes out and the letter starts over.
            if (!hit) begin
                emit_char(ValueWidth'(CH_BACKSLASH));
                take_fresh(b);
            end
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int h;
        case (dec_phase)
            PH_ESC: begin
                open_escape(b);
            end
            PH_CTRL: begin
                // The control code goes out, then the same byte is read again.
                clear_escape();
                emit_char(ValueWidth'(b & CTRL_MASK));
                take_fresh(b);
            end
            PH_OCT: begin
                if (b >= CH_0 && b <= CH_7) begin
                    dec_acc  = (dec_acc << 3) + ValueWidth'(b - CH_0);
                    dec_seen = dec_seen + 3'd1;
                    if (dec_seen >= dec_allowed) begin
                        emit_char(dec_acc);
                        clear_escape();
                    end
                end else begin
                    emit_char(dec_acc);
                    clear_escape();
                    take_fresh(b);
                end
            end
            PH_HEX: begin
                h = hex_digit_value(b);
                if (h >= 0) begin
                    dec_acc  = {dec_acc[ValueWidth-5:0], 4'(h)};
                    dec_seen = dec_seen + 3'd1;
                    if (dec_seen >= dec_allowed) begin
                        emit_char(dec_acc);
                        clear_escape();
                    end
                end else begin
                    close_hex();
                    take_fresh(b);
                end
            end
            default: begin
                clear_escape();
                take_fresh(b);
            end
        endcase
    endfunction

    // End of text: whatever escape is still open is closed out.
    function automatic void flush_escape();
        case (dec_phase)
            PH_ESC:  emit_char(ValueWidth'(CH_BACKSLASH));
            PH_CTRL: emit_char('0);
            PH_OCT:  emit_char(dec_acc);
            PH_HEX:  close_hex();
            default: ;
        endcase
        clear_escape();
    endfunction

    // Works out the characters that one accepted byte causes and queues them.
    function automatic void predict_item(input t_in_item it);
        t_out_item r;
        step_cnt = 0;
        decode_byte(it.in_byte);
        if (it.end_of_text) begin
            flush_escape();
        end
        for (int k = 0; k < step_cnt; k++) begin
            r.char_value = step_vals[k];
            r.run_last   = (k == step_cnt - 1);
            expected_chars.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: bursts of back-to-back transfers separated by random gaps.
    // The prediction is made at the edge where the transfer happens, so the
    // predictor always sees the bytes in the order the block takes them.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_item(i_in_data);
            end
            // A new byte may be put up only once the current one has been taken.
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 && !tx_steady) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_bytes.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side back-pressure: ready follows a 16-bit random pattern that is
    // redrawn every lap; bit 0 is always set, so ready comes at least once per lap.
    always @(posedge i_clk) begin
        i_out_ready <= rx_steady | stall_pattern[stall_pos];
        stall_pos   <= stall_pos + 4'd1;
        if (stall_pos == 4'd15) begin
            stall_pattern <= 16'($urandom) | 16'h0001;
        end
    end

    // Output monitor: every result transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char_value %h run_last %b",
                                          o_out_data.char_value, o_out_data.run_last));
            end else begin
                want = expected_chars.pop_front();
                if (o_out_data.char_value !== want.char_value) begin
                    report_mismatch($sformatf("char_value %h, expected %h",
                                              o_out_data.char_value, want.char_value));
                end
                if (o_out_data.run_last !== want.run_last) begin
                    report_mismatch($sformatf("run_last %b, expected %b (char_value %h)",
                                              o_out_data.run_last, want.run_last,
                                              want.char_value));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration access and stimulus helpers.
    // ------------------------------------------------------------------

    // One register access: setup cycle, then access cycle; the write lands (and read
    // data is taken) at the edge that ends the access cycle.
    task automatic cfg_access(input logic wr, input logic [AddrWidth-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes echo_mode with random upper bits, then reads it back.
    task automatic set_echo(input logic v);
        logic [31:0] wd;
        logic [31:0] rd;
        wd    = $urandom;
        wd[0] = v;
        cfg_access(1'b1, ADDR_ECHO, wd, rd);
        echo_on = v;
        cfg_access(1'b0, ADDR_ECHO, 32'h0, rd);
        if (rd[0] !== v) begin
            report_mismatch($sformatf("echo_mode reads %b after writing %b", rd[0], v));
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic eot);
        t_in_item it;
        it.in_byte     = b;
        it.end_of_text = eot;
        pending_bytes.push_back(it);
    endtask

    // A byte of running text; now and then the string ends on it, which also cuts
    // off any escape that happens to be open at that point.
    task automatic add_text(input logic [7:0] b);
        add_byte(b, $urandom_range(0, 11) == 0);
    endtask

    // One random token, mostly well-formed escapes with random content.
    task automatic add_token(input logic echo);
        int kind;
        int n;
        int d;
        kind = $urandom_range(0, 15);
        case (kind)
            0, 1: add_text(8'($urandom_range(32, 126)));
            2:    add_text(8'($urandom));
            3, 4: begin
                add_text(CH_BACKSLASH);
                add_text(SHORT_ESC_CHAR[$urandom_range(0, NumShortEsc - 1)]);
            end
            5, 6: begin
                add_text(CH_BACKSLASH);
                add_text(CH_C);
                add_text(($urandom_range(0, 3) == 0) ? CH_BACKSLASH : 8'($urandom));
            end
            7, 8, 9: begin
                // Octal; up to one digit past the limit so the extra one reads as text.
                add_text(CH_BACKSLASH);
                if (echo) begin
                    add_text(CH_0);
                    n = $urandom_range(0, 4);
                end else begin
                    n = $urandom_range(1, 4);
                end
                repeat (n) add_text(CH_0 + 8'($urandom_range(0, 7)));
                add_text(8'($urandom_range(32, 126)));
            end
            10, 11, 12: begin
                add_text(CH_BACKSLASH);
                add_text(HEX_ESC_CHAR[$urandom_range(0, 2)]);
                n = $urandom_range(0, 7);
                repeat (n) begin
                    d = $urandom_range(0, 21);
                    if (d < 10) begin
                        add_text(CH_0 + 8'(d));
                    end else if (d < 16) begin
                        add_text(CH_LO_A + 8'(d - 10));
                    end else begin
                        add_text(CH_UP_A + 8'(d - 16));
                    end
                end
                add_text(8'($urandom_range(32, 126)));
            end
            13: begin
                add_text(CH_BACKSLASH);
                add_text(8'($urandom));
            end
            14: add_byte(CH_BACKSLASH, 1'b1);
            default: begin
                add_text(CH_BACKSLASH);
                add_text(CH_BACKSLASH);
            end
        endcase
    endtask

    // Waits until every byte has been taken and every character has come back, then
    // gives a byte that produced nothing time to settle inside the block.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_in_valid || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] rd;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A write past the register list must leave echo_mode at its reset value.
        cfg_access(1'b1, ADDR_BEYOND, 32'h0, rd);
        cfg_access(1'b0, ADDR_ECHO, 32'h0, rd);
        if (rd[0] !== 1'b1) begin
            report_mismatch("echo_mode changed by a write past the register list");
        end

        // Directed part in echo style. Queues are filled on the falling edge so the
        // driver never races with them.
        @(negedge i_clk);
        add_byte(8'h00, 1'b0);                // byte zero is plain text
        add_byte(8'hFF, 1'b1);                // top byte value, string ends while idle
        add_byte(CH_BACKSLASH, 1'b0);         // control escape, then the letter again
        add_byte(CH_C, 1'b0);
        add_byte("A", 1'b0);
        add_byte(CH_BACKSLASH, 1'b0);         // octal behind a leading zero, full length
        add_byte(CH_0, 1'b0);
        repeat (3) add_byte(CH_7, 1'b0);
        add_byte(CH_BACKSLASH, 1'b0);         // hex escape with no digits: three chars
        add_byte(CH_X, 1'b0);
        add_byte("g", 1'b0);
        add_byte(CH_BACKSLASH, 1'b0);         // widest code point value
        add_byte(CH_UP_U, 1'b0);
        repeat (6) add_byte(CH_UP_F, 1'b0);
        add_byte(CH_BACKSLASH, 1'b0);         // unknown escape letter
        add_byte("q", 1'b0);
        add_byte(CH_BACKSLASH, 1'b1);         // trailing backslash passes through
        wait_drained();

        // Bare octal digits, cut off by the end of the string.
        set_echo(1'b0);
        @(negedge i_clk);
        add_byte(CH_BACKSLASH, 1'b0);
        add_byte(CH_7, 1'b1);
        wait_drained();

        // Random phases. echo_mode flips between phases, and since a phase may stop
        // in the middle of an escape, some flips land on a half-decoded escape.
        for (int p = 0; p < 6; p++) begin
            set_echo(!p[0]);
            @(negedge i_clk);
            tx_steady = (p == 2);
            rx_steady = (p == 3);
            while (pending_bytes.size() < 47) begin
                add_token(!p[0]);
            end
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** backslash_escape_decoder_top: PASSED **");
        end else begin
            $display("** backslash_escape_decoder_top: FAILED **");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #400_000;
        $display("** backslash_escape_decoder_top: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bsed_pkg.sv
rtl/core/bsed_cfg.sv
rtl/core/bsed_step.sv
rtl/core/bsed_out.sv
rtl/core/backslash_escape_decoder_top.sv
bench/tb_top.sv
